// ----- sv/opd_pkg.sv -----
// Shared types, constants and tables for the orbit position pipeline.
package opd_pkg;

  // CORDIC setup
  localparam int CORDIC_ITERATIONS = 16;
  localparam int TRIG_FRAC_BITS    = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int IDX_W             = $clog2(ATAN_ENTRIES);

  // Field widths
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int HOUR_W   = 5;
  localparam int YEAR_W   = 12;
  localparam int RADIUS_W = 8;
  localparam int PERIOD_W = 14;
  localparam int OFFS_W   = 11;
  localparam int CENTER_W = 9;
  localparam int ANG_W    = 12;
  localparam int POS_W    = 11;

  // Divider chain widths
  localparam int NUM_W      = 38;
  localparam int QUO_W      = 10;
  localparam int MOD_STEPS  = 14;
  localparam int BASE_STEPS = 10;
  localparam int SHIFT_W    = $clog2(MOD_STEPS);

  // Angle and trig widths
  localparam int ZABS_W = 35;
  localparam int ZW     = 33;
  localparam int XY_W   = TRIG_FRAC_BITS + 4;
  localparam int PROD_W = XY_W + RADIUS_W + 1;

  // Q30 angle constants
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN    = 64'sd652032874;
  localparam longint K_INIT      = (Q30_GAIN + ((64'sd1 << (30 - TRIG_FRAC_BITS)) / 2))
                                   >>> (30 - TRIG_FRAC_BITS);

  localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // Days before the start of each month, plain year
  localparam logic [8:0] CUM_DAYS [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_PERIOD   = 3'd1,
    REG_OFFSET   = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4
  } cfg_reg_t;

  // Item moving through a restoring divider cell
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_item_t;

  // Item moving through a CORDIC cell
  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic                    flip;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ZW-1:0]    z;
  } cordic_item_t;

endpackage

// ----- sv/opd_div_cell.sv -----
// One restoring division step: compare against shifted divisor, subtract, shift in a quotient bit.
module opd_div_cell
  import opd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  div_item_t            in_item,
  input  logic [NUM_W-1:0]     den,
  input  logic [SHIFT_W-1:0]   shift,
  output logic                 out_valid,
  input  logic                 out_ready,
  output div_item_t            out_item
);

  logic [NUM_W-1:0] dsh;
  logic             ge;
  div_item_t        res;

  // trial subtract
  always_comb begin
    dsh     = den << shift;
    ge      = (in_item.num >= dsh);
    res.num = ge ? (in_item.num - dsh) : in_item.num;
    res.quo = {in_item.quo[QUO_W-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= res;
    end
  end

endmodule

// ----- sv/opd_cordic_cell.sv -----
// One CORDIC rotation step with floor shifts and a Q30 arctangent entry.
module opd_cordic_cell
  import opd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cordic_item_t       in_item,
  input  logic [IDX_W-1:0]   idx,
  output logic               out_valid,
  input  logic               out_ready,
  output cordic_item_t       out_item
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [ZW-1:0]   at;
  cordic_item_t           res;

  // rotate toward zero residual angle
  always_comb begin
    xs  = in_item.x >>> idx;
    ys  = in_item.y >>> idx;
    at  = ZW'(ATAN_Q30[idx]);
    res = in_item;
    if (!in_item.z[ZW-1]) begin
      res.x = in_item.x - ys;
      res.y = in_item.y + xs;
      res.z = in_item.z - at;
    end else begin
      res.x = in_item.x + ys;
      res.y = in_item.y - xs;
      res.z = in_item.z + at;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= res;
    end
  end

endmodule

// ----- sv/orbit_position_from_date_unit.sv -----
// Top level: date to orbit angle and position, as a pipeline of divider and CORDIC cells.
//
// Takes one date per cycle and returns the orbit angle in centiradians and the x/y position
// one item per cycle. It is built of a day-of-year stage, 14 divider cells
// for the hour-within-period remainder, a scaling stage, 10 divider cells for the scaled
// angle, five angle stages, 16 CORDIC cells and three output stages. Every stage holds its
// item under backpressure and refills as soon as its successor moves, so throughput is one
// item per cycle whenever the output side keeps up. Configuration writes are taken at any
// time (ready always high) and must only be issued while the pipeline is empty.
module orbit_position_from_date_unit
  import opd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request in: day_of_month[4:0], month_number[8:5], hour_of_day[13:9], year_number[25:14]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // result out: angle_centirad[11:0], pos_x[22:12], pos_y[33:23]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam logic signed [35:0] PI_36      = 36'(Q30_PI);
  localparam logic signed [35:0] HALF_PI_36 = 36'(Q30_HALF_PI);
  localparam logic [ZABS_W-1:0]  PI_1       = ZABS_W'(Q30_PI);
  localparam logic [ZABS_W-1:0]  PI_3       = ZABS_W'(3 * Q30_PI);
  localparam logic [ZABS_W-1:0]  PI_5       = ZABS_W'(5 * Q30_PI);
  localparam logic signed [35:0] TURN_1     = 36'(Q30_TWO_PI);
  localparam logic signed [35:0] TURN_2     = 36'(2 * Q30_TWO_PI);
  localparam logic signed [35:0] TURN_3     = 36'(3 * Q30_TWO_PI);

  // configuration registers
  logic [RADIUS_W-1:0]      orbit_radius;
  logic [PERIOD_W-1:0]      period_hours;
  logic signed [OFFS_W-1:0] phase_offset;
  logic [CENTER_W-1:0]      center_x;
  logic [CENTER_W-1:0]      center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_radius <= RADIUS_W'(100);
      period_hours <= PERIOD_W'(8760);
      phase_offset <= '0;
      center_x     <= '0;
      center_y     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:   orbit_radius <= cfg_data[RADIUS_W-1:0];
        REG_PERIOD:   period_hours <= cfg_data[PERIOD_W-1:0];
        REG_OFFSET:   phase_offset <= cfg_data[OFFS_W-1:0];
        REG_CENTER_X: center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y: center_y     <= cfg_data[CENTER_W-1:0];
        default:      ;
      endcase
    end
  end

  // divisors, to be kept stable by the user while items are in flight; the block does not enforce it
  logic [PERIOD_W-1:0] period_eff;
  logic [NUM_W-1:0]    den_mod;
  logic [NUM_W-1:0]    den_base;

  assign period_eff = (period_hours == '0) ? PERIOD_W'(1) : period_hours;
  assign den_mod    = NUM_W'(period_eff);
  assign den_base   = NUM_W'(period_eff) * NUM_W'(10000);

  // ---------------- stage 0: day of year and hour count ----------------
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [HOUR_W-1:0]  in_hour;
  logic [YEAR_W-1:0]  in_year;
  logic [24:0]        year_prod;
  logic               div100;
  logic               div400;
  logic               leap;
  logic [3:0]         whole;
  logic [8:0]         doy;
  logic [13:0]        hour_cnt;

  assign in_day   = s_axis_tdata[4:0];
  assign in_month = s_axis_tdata[8:5];
  assign in_hour  = s_axis_tdata[13:9];
  assign in_year  = s_axis_tdata[25:14];

  always_comb begin
    // year * 2^19/100: a multiple of 100 leaves a small low part
    year_prod = 25'(in_year) * 25'd5243;
    div100    = (year_prod[18:0] < 19'd5243);
    div400    = div100 && (year_prod[20:19] == 2'b00);
    leap      = (in_year[1:0] == 2'b00) && (!div100 || div400);
    if (in_month == '0) begin
      whole = 4'd0;
    end else if (in_month > 4'd13) begin
      whole = 4'd12;
    end else begin
      whole = in_month - 4'd1;
    end
    doy      = CUM_DAYS[whole] + 9'((whole >= 4'd2) && leap) + 9'(in_day);
    hour_cnt = {1'b0, doy, 4'b0} + {2'b0, doy, 3'b0} + 14'(in_hour);
  end

  logic        s0_valid;
  logic        s0_ready;
  div_item_t   s0_item;

  assign s_axis_tready = !s0_valid || s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s0_item.num <= NUM_W'(hour_cnt);
      s0_item.quo <= '0;
    end
  end

  // ---------------- remainder chain: hours mod period ----------------
  logic      mod_valid [MOD_STEPS+1];
  logic      mod_ready [MOD_STEPS+1];
  div_item_t mod_item  [MOD_STEPS+1];

  assign mod_valid[0] = s0_valid;
  assign mod_item[0]  = s0_item;
  assign s0_ready     = mod_ready[0];

  for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
    opd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (mod_valid[i]),
      .in_ready  (mod_ready[i]),
      .in_item   (mod_item[i]),
      .den       (den_mod),
      .shift     (SHIFT_W'(MOD_STEPS - 1 - i)),
      .out_valid (mod_valid[i+1]),
      .out_ready (mod_ready[i+1]),
      .out_item  (mod_item[i+1])
    );
  end

  // ---------------- stage 1: scale hours by 2*pi*10^6 ----------------
  logic      s1_valid;
  logic      s1_ready;
  div_item_t s1_item;

  assign mod_ready[MOD_STEPS] = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mod_ready[MOD_STEPS]) begin
      s1_valid <= mod_valid[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (mod_valid[MOD_STEPS] && mod_ready[MOD_STEPS]) begin
      s1_item.num <= NUM_W'(mod_item[MOD_STEPS].num[PERIOD_W-1:0]) * NUM_W'(6283185);
      s1_item.quo <= '0;
    end
  end

  // ---------------- quotient chain: base angle ----------------
  logic      base_valid [BASE_STEPS+1];
  logic      base_ready [BASE_STEPS+1];
  div_item_t base_item  [BASE_STEPS+1];

  assign base_valid[0] = s1_valid;
  assign base_item[0]  = s1_item;
  assign s1_ready      = base_ready[0];

  for (genvar i = 0; i < BASE_STEPS; i++) begin : g_base
    opd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (base_valid[i]),
      .in_ready  (base_ready[i]),
      .in_item   (base_item[i]),
      .den       (den_base),
      .shift     (SHIFT_W'(BASE_STEPS - 1 - i)),
      .out_valid (base_valid[i+1]),
      .out_ready (base_ready[i+1]),
      .out_item  (base_item[i+1])
    );
  end

  // ---------------- stage 2: add angle offset ----------------
  logic                    s2_valid;
  logic                    s2_ready;
  logic signed [ANG_W-1:0] s2_angle;

  assign base_ready[BASE_STEPS] = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (base_ready[BASE_STEPS]) begin
      s2_valid <= base_valid[BASE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (base_valid[BASE_STEPS] && base_ready[BASE_STEPS]) begin
      s2_angle <= $signed({2'b00, base_item[BASE_STEPS].quo})
                + $signed({phase_offset[OFFS_W-1], phase_offset});
    end
  end

  // ---------------- stage 3: |angle| * 2^30 / 100 ----------------
  // 2^28 = 25*10737418 + 6, so a*2^28/25 = a*10737418 + floor(6a/25)
  logic [ANG_W-1:0]  ang_abs;
  logic [35:0]       z_whole;
  logic [30:0]       z_frac;

  always_comb begin
    ang_abs = s2_angle[ANG_W-1] ? ANG_W'(-s2_angle) : ANG_W'(s2_angle);
    z_whole = 36'(ang_abs) * 36'd10737418;
    z_frac  = (31'(ang_abs) * 31'd251664) >> 20;
  end

  logic                    s3_valid;
  logic                    s3_ready;
  logic signed [ANG_W-1:0] s3_angle;
  logic                    s3_neg;
  logic [ZABS_W-1:0]       s3_zabs;

  assign s2_ready = !s3_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      s3_angle <= s2_angle;
      s3_neg   <= s2_angle[ANG_W-1];
      s3_zabs  <= ZABS_W'(z_whole) + ZABS_W'(z_frac);
    end
  end

  // ---------------- stage 4: remove whole turns from the magnitude ----------------
  logic signed [35:0] turns;
  logic signed [35:0] z_red;

  always_comb begin
    if (s3_zabs > PI_5) begin
      turns = TURN_3;
    end else if (s3_zabs > PI_3) begin
      turns = TURN_2;
    end else if (s3_zabs > PI_1) begin
      turns = TURN_1;
    end else begin
      turns = '0;
    end
    z_red = $signed({1'b0, s3_zabs}) - turns;
  end

  logic                    s4_valid;
  logic                    s4_ready;
  logic signed [ANG_W-1:0] s4_angle;
  logic                    s4_neg;
  logic signed [ZW-1:0]    s4_z;

  assign s3_ready = !s4_valid || s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s3_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      s4_angle <= s3_angle;
      s4_neg   <= s3_neg;
      s4_z     <= z_red[ZW-1:0];
    end
  end

  // ---------------- stage 5: fold into the right half plane ----------------
  logic signed [35:0] z_wide;
  logic signed [35:0] z_fold;
  logic               fold;

  always_comb begin
    z_wide = 36'(s4_z);
    if (z_wide > HALF_PI_36) begin
      z_fold = z_wide - PI_36;
      fold   = 1'b1;
    end else if (z_wide < -HALF_PI_36) begin
      z_fold = z_wide + PI_36;
      fold   = 1'b1;
    end else begin
      z_fold = z_wide;
      fold   = 1'b0;
    end
  end

  logic                    s5_valid;
  logic                    s5_ready;
  logic signed [ANG_W-1:0] s5_angle;
  logic                    s5_neg;
  logic                    s5_flip;
  logic signed [ZW-1:0]    s5_z;

  assign s4_ready = !s5_valid || s5_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s4_ready) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && s4_ready) begin
      s5_angle <= s4_angle;
      s5_neg   <= s4_neg;
      s5_flip  <= fold;
      s5_z     <= z_fold[ZW-1:0];
    end
  end

  // ---------------- stage 6: restore sign, load CORDIC start ----------------
  logic         s6_valid;
  cordic_item_t s6_item;

  logic         cor_valid [CORDIC_STEPS+1];
  logic         cor_ready [CORDIC_STEPS+1];
  cordic_item_t cor_item  [CORDIC_STEPS+1];

  assign s5_ready = !s6_valid || cor_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (s5_ready) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_valid && s5_ready) begin
      s6_item.angle <= s5_angle;
      s6_item.flip  <= s5_flip;
      s6_item.x     <= XY_W'(K_INIT);
      s6_item.y     <= '0;
      s6_item.z     <= s5_neg ? -s5_z : s5_z;
    end
  end

  // ---------------- CORDIC chain ----------------
  assign cor_valid[0] = s6_valid;
  assign cor_item[0]  = s6_item;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    opd_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cor_valid[i]),
      .in_ready  (cor_ready[i]),
      .in_item   (cor_item[i]),
      .idx       (IDX_W'(i)),
      .out_valid (cor_valid[i+1]),
      .out_ready (cor_ready[i+1]),
      .out_item  (cor_item[i+1])
    );
  end

  // ---------------- stage 7: undo the half-plane fold ----------------
  cordic_item_t cor_last;

  assign cor_last = cor_item[CORDIC_STEPS];

  logic                    s7_valid;
  logic                    s7_ready;
  logic signed [ANG_W-1:0] s7_angle;
  logic signed [XY_W-1:0]  s7_x;
  logic signed [XY_W-1:0]  s7_y;

  assign cor_ready[CORDIC_STEPS] = !s7_valid || s7_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (cor_ready[CORDIC_STEPS]) begin
      s7_valid <= cor_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (cor_valid[CORDIC_STEPS] && cor_ready[CORDIC_STEPS]) begin
      s7_angle <= cor_last.angle;
      s7_x     <= cor_last.flip ? -cor_last.x : cor_last.x;
      s7_y     <= cor_last.flip ? -cor_last.y : cor_last.y;
    end
  end

  // ---------------- stage 8: scale by radius ----------------
  logic signed [RADIUS_W:0] radius_s;

  assign radius_s = $signed({1'b0, orbit_radius});

  logic                    s8_valid;
  logic                    s8_ready;
  logic signed [ANG_W-1:0] s8_angle;
  logic signed [PROD_W-1:0] s8_px;
  logic signed [PROD_W-1:0] s8_py;

  assign s7_ready = !s8_valid || s8_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (s7_ready) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_valid && s7_ready) begin
      s8_angle <= s7_angle;
      s8_px    <= PROD_W'(radius_s) * PROD_W'(s7_x);
      s8_py    <= PROD_W'(radius_s) * PROD_W'(s7_y);
    end
  end

  // ---------------- stage 9: truncate toward zero, add center ----------------
  localparam logic signed [PROD_W-1:0] ROUND_IN = PROD_W'((64'sd1 << TRIG_FRAC_BITS) - 1);

  logic signed [PROD_W-1:0] qx;
  logic signed [PROD_W-1:0] qy;

  always_comb begin
    qx = s8_px[PROD_W-1] ? ((s8_px + ROUND_IN) >>> TRIG_FRAC_BITS)
                         : (s8_px >>> TRIG_FRAC_BITS);
    qy = s8_py[PROD_W-1] ? ((s8_py + ROUND_IN) >>> TRIG_FRAC_BITS)
                         : (s8_py >>> TRIG_FRAC_BITS);
  end

  logic             s9_valid;
  logic [ANG_W-1:0] s9_angle;
  logic [POS_W-1:0] s9_x;
  logic [POS_W-1:0] s9_y;

  assign s8_ready = !s9_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (s8_ready) begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s8_valid && s8_ready) begin
      s9_angle <= s8_angle;
      s9_x     <= qx[POS_W-1:0] + POS_W'(center_x);
      s9_y     <= qy[POS_W-1:0] + POS_W'(center_y);
    end
  end

  assign m_axis_tvalid = s9_valid;
  assign m_axis_tdata  = {6'b0, s9_y, s9_x, s9_angle};

endmodule
